/* rtl/assert_macros.svh */
// assertion helpers, clocked on i_clk and disabled while i_rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge
`define TPQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// implication checked in the same cycle
`define TPQ_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

`endif

/* rtl/tpq_pkg.sv */
`timescale 1ns / 1ps

package tpq_pkg;

    // field widths
    localparam int HANDLE_W   = 32;
    localparam int LEN_IN_W   = 16;
    localparam int LEN_W      = 12;
    localparam int TIME_W     = 32;
    localparam int LOOK_W     = 10;
    localparam int QUEUED_W   = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // defaults
    localparam int RING_SLOTS_DEF = 512;
    localparam logic [LOOK_W-1:0] LOOKAHEAD_RST     = LOOK_W'(150);
    localparam logic [LEN_W-1:0]  SILENCE_LEN_RST   = LEN_W'(1408);
    localparam logic [LEN_W-1:0]  MAX_FRAME_LEN_RST = LEN_W'(2048);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_ENABLE    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_LOOKAHEAD_MS  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_SILENCE_LEN   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME_LEN = CFG_IDX_W'(3);

    typedef enum logic [2:0] {
        OP_WRITE     = 3'd0,
        OP_TICK      = 3'd1,
        OP_FLUSH     = 3'd2,
        OP_SET_SKIP  = 3'd3,
        OP_SET_PAUSE = 3'd4,
        OP_SET_START = 3'd5,
        OP_START     = 3'd6,
        OP_STOP      = 3'd7
    } t_op;

    typedef enum logic [2:0] {
        KIND_NONE    = 3'd0,
        KIND_ACCEPT  = 3'd1,
        KIND_REJECT  = 3'd2,
        KIND_PLAY    = 3'd3,
        KIND_SILENCE = 3'd4,
        KIND_TAP     = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SECOND
    } t_state;

    // classified command from the front end
    typedef struct packed {
        t_op                 op;
        logic                len_over;
        logic [HANDLE_W-1:0] handle;
        logic [LEN_W-1:0]    len;
        logic [TIME_W-1:0]   opnd;
    } t_cmd;

    // configuration registers
    typedef struct packed {
        logic              tap_enable;
        logic [LOOK_W-1:0] lookahead_ms;
        logic [LEN_W-1:0]  silence_len;
        logic [LEN_W-1:0]  max_frame_len;
    } t_cfg;

    // one ring entry
    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [LEN_W-1:0]    len;
        logic [TIME_W-1:0]   play_time;
    } t_slot;

endpackage

/* rtl/tpq_front.sv */
`timescale 1ns / 1ps

module tpq_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [2:0]                    i_op,
    input  logic [tpq_pkg::HANDLE_W-1:0]  i_frame_handle,
    input  logic [tpq_pkg::LEN_IN_W-1:0]  i_frame_len,
    input  logic [tpq_pkg::TIME_W-1:0]    i_time_value,
    input  logic [tpq_pkg::TIME_W-1:0]    i_now_ms,
    input  logic [tpq_pkg::TIME_W-1:0]    i_count,
    input  tpq_pkg::t_cfg                 i_cfg,
    output logic                          o_push_valid,
    output tpq_pkg::t_cmd                 o_cmd,
    input  logic                          i_push_ready
);

    logic          r_valid;
    tpq_pkg::t_cmd r_cmd;
    tpq_pkg::t_cmd n_cmd;
    logic          accept;

    assign o_stall      = r_valid && !i_push_ready;
    assign accept       = i_valid && !o_stall;
    assign o_push_valid = r_valid;
    assign o_cmd        = r_cmd;

    // classify the item and pick its operand
    always_comb begin
        n_cmd          = '0;
        n_cmd.op       = tpq_pkg::t_op'(i_op);
        n_cmd.handle   = i_frame_handle;
        n_cmd.len      = i_frame_len[tpq_pkg::LEN_W-1:0];
        n_cmd.len_over = i_frame_len > tpq_pkg::LEN_IN_W'(i_cfg.max_frame_len);
        case (tpq_pkg::t_op'(i_op))
            tpq_pkg::OP_WRITE:     n_cmd.opnd = i_time_value;
            tpq_pkg::OP_SET_START: n_cmd.opnd = i_time_value;
            tpq_pkg::OP_TICK:      n_cmd.opnd = i_now_ms;
            tpq_pkg::OP_SET_SKIP:  n_cmd.opnd = i_count;
            tpq_pkg::OP_SET_PAUSE: n_cmd.opnd = i_count;
            default:               n_cmd.opnd = '0;
        endcase
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_push_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

/* rtl/tpq_cmd_fifo.sv */
`timescale 1ns / 1ps

module tpq_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    input  tpq_pkg::t_cmd i_cmd,
    output logic          o_pop_valid,
    input  logic          i_pop,
    output tpq_pkg::t_cmd o_cmd
);

    tpq_pkg::t_cmd r_slot [2];
    logic          r_wr_sel;
    logic          r_rd_sel;
    logic [1:0]    r_count;
    logic          push;
    logic          pop;

    assign o_push_ready = r_count != 2'd2;
    assign o_pop_valid  = r_count != 2'd0;
    assign o_cmd        = r_slot[r_rd_sel];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_pop_valid;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_sel <= 1'b0;
            r_rd_sel <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_sel <= !r_wr_sel;
            end
            if (pop) begin
                r_rd_sel <= !r_rd_sel;
            end
            if (push && !pop) begin
                r_count <= r_count + 2'd1;
            end else if (pop && !push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_sel] <= i_cmd;
        end
    end

endmodule

/* rtl/tpq_back.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tpq_back #(
    parameter int RING_SLOTS = tpq_pkg::RING_SLOTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cmd_valid,
    output logic                           o_cmd_pop,
    input  tpq_pkg::t_cmd                  i_cmd,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [tpq_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tpq_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output tpq_pkg::t_cfg                  o_cfg,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [2:0]                     o_kind,
    output logic [tpq_pkg::HANDLE_W-1:0]   o_out_handle,
    output logic [tpq_pkg::LEN_W-1:0]      o_out_len,
    output logic [tpq_pkg::TIME_W-1:0]     o_out_time,
    output logic [tpq_pkg::QUEUED_W-1:0]   o_frames_queued,
    output logic [tpq_pkg::TIME_W-1:0]     o_newest_time,
    output logic                           o_last
);

    localparam int PTR_W = $clog2(RING_SLOTS);
    localparam int QW    = (PTR_W > tpq_pkg::QUEUED_W) ? PTR_W : tpq_pkg::QUEUED_W;
    localparam logic [PTR_W:0] SLOTS = (PTR_W + 1)'(RING_SLOTS);

    // next pointer around the ring
    function automatic logic [PTR_W-1:0] f_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] res;
        if ((PTR_W + 1)'(p) == SLOTS - (PTR_W + 1)'(1)) begin
            res = '0;
        end else begin
            res = p + PTR_W'(1);
        end
        return res;
    endfunction

    // frames held between read and write pointers
    function automatic logic [PTR_W-1:0] f_occ(input logic [PTR_W-1:0] wp,
                                               input logic [PTR_W-1:0] rp);
        logic [PTR_W:0] diff;
        diff = (PTR_W + 1)'(wp) - (PTR_W + 1)'(rp);
        if (diff[PTR_W]) begin
            diff = diff + SLOTS;
        end
        return diff[PTR_W-1:0];
    endfunction

    tpq_pkg::t_slot r_mem [RING_SLOTS];
    tpq_pkg::t_slot r_rd;

    tpq_pkg::t_state r_state, n_state;
    tpq_pkg::t_cmd   r_cmd;
    tpq_pkg::t_cfg   r_cfg;

    logic [PTR_W-1:0]           r_rp, n_rp;
    logic [PTR_W-1:0]           r_wp, n_wp;
    logic                       r_tapped, n_tapped;
    logic [31:0]                r_skip, n_skip;
    logic [31:0]                r_pause, n_pause;
    logic [tpq_pkg::TIME_W-1:0] r_start, n_start;
    logic                       r_active, n_active;
    logic [tpq_pkg::TIME_W-1:0] r_newest, n_newest;

    logic                         r_out_valid;
    tpq_pkg::t_kind               r_out_kind;
    logic [tpq_pkg::HANDLE_W-1:0] r_out_handle;
    logic [tpq_pkg::LEN_W-1:0]    r_out_len;
    logic [tpq_pkg::TIME_W-1:0]   r_out_time;
    logic [tpq_pkg::QUEUED_W-1:0] r_out_queued;
    logic [tpq_pkg::TIME_W-1:0]   r_out_newest;
    logic                         r_out_last;

    logic out_free;
    logic cmd_pop;
    logic exec_go;
    logic second_go;

    logic                         mem_we;
    tpq_pkg::t_kind               res_kind;
    logic [tpq_pkg::HANDLE_W-1:0] res_handle;
    logic [tpq_pkg::LEN_W-1:0]    res_len;
    logic [tpq_pkg::TIME_W-1:0]   res_time;
    logic                         res_two;

    logic [PTR_W-1:0]           occ_cur;
    logic [PTR_W-1:0]           occ_next;
    logic [QW-1:0]              occ_wide;
    logic [tpq_pkg::TIME_W-1:0] newest_next;
    logic [PTR_W-1:0]           skip_drop;
    logic [PTR_W:0]             skip_sum;
    logic [tpq_pkg::TIME_W-1:0] tap_limit;
    logic                       tap_hit;
    logic                       play_hit;

    assign out_free    = !r_out_valid || !i_stall;
    assign o_cmd_pop   = cmd_pop;
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tpq_pkg::ST_IDLE: begin
                if (i_cmd_valid) begin
                    n_state = tpq_pkg::ST_EXEC;
                end
            end
            tpq_pkg::ST_EXEC: begin
                if (out_free) begin
                    n_state = res_two ? tpq_pkg::ST_SECOND : tpq_pkg::ST_IDLE;
                end
            end
            tpq_pkg::ST_SECOND: begin
                if (out_free) begin
                    n_state = tpq_pkg::ST_IDLE;
                end
            end
            default: n_state = tpq_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        cmd_pop   = 1'b0;
        exec_go   = 1'b0;
        second_go = 1'b0;
        case (r_state)
            tpq_pkg::ST_IDLE:   cmd_pop   = i_cmd_valid;
            tpq_pkg::ST_EXEC:   exec_go   = out_free;
            tpq_pkg::ST_SECOND: second_go = out_free;
            default: ;
        endcase
    end

    // head checks for a tick
    assign occ_cur   = f_occ(r_wp, r_rp);
    assign tap_limit = r_rd.play_time - tpq_pkg::TIME_W'(r_cfg.lookahead_ms);
    assign tap_hit   = r_cfg.tap_enable && !r_tapped && (r_rd.play_time != '0)
                       && (r_cmd.opnd >= tap_limit);
    assign play_hit  = r_cmd.opnd >= r_rd.play_time;
    assign skip_drop = (r_skip < 32'(occ_cur)) ? r_skip[PTR_W-1:0] : occ_cur;
    assign skip_sum  = (PTR_W + 1)'(r_rp) + (PTR_W + 1)'(skip_drop);

    // command execution
    always_comb begin
        n_rp       = r_rp;
        n_wp       = r_wp;
        n_tapped   = r_tapped;
        n_skip     = r_skip;
        n_pause    = r_pause;
        n_start    = r_start;
        n_active   = r_active;
        n_newest   = r_newest;
        mem_we     = 1'b0;
        res_kind   = tpq_pkg::KIND_NONE;
        res_handle = '0;
        res_len    = '0;
        res_time   = '0;
        res_two    = 1'b0;
        case (r_cmd.op)
            tpq_pkg::OP_WRITE: begin
                if (r_cmd.len_over || f_inc(r_wp) == r_rp) begin
                    res_kind = tpq_pkg::KIND_REJECT;
                end else begin
                    mem_we   = exec_go;
                    n_wp     = f_inc(r_wp);
                    n_newest = r_cmd.opnd;
                    res_kind = tpq_pkg::KIND_ACCEPT;
                end
            end
            tpq_pkg::OP_TICK: begin
                if (!r_active || r_start == '0) begin
                    res_kind = tpq_pkg::KIND_NONE;
                end else if (r_skip != '0) begin
                    // drop queued frames against the skip count
                    if (skip_sum >= SLOTS) begin
                        n_rp = PTR_W'(skip_sum - SLOTS);
                    end else begin
                        n_rp = skip_sum[PTR_W-1:0];
                    end
                    if (skip_drop != '0) begin
                        n_tapped = 1'b0;
                    end
                    n_skip = r_skip - 32'(skip_drop);
                end else if (r_pause != '0) begin
                    n_pause  = r_pause - 32'd1;
                    res_kind = tpq_pkg::KIND_SILENCE;
                    res_len  = r_cfg.silence_len;
                end else if (occ_cur != '0) begin
                    res_handle = r_rd.handle;
                    res_len    = r_rd.len;
                    res_time   = r_rd.play_time;
                    if (tap_hit) begin
                        n_tapped = 1'b1;
                        res_kind = tpq_pkg::KIND_TAP;
                    end
                    if (play_hit) begin
                        n_rp     = f_inc(r_rp);
                        n_tapped = 1'b0;
                        if (tap_hit) begin
                            res_two = 1'b1;
                        end else begin
                            res_kind = tpq_pkg::KIND_PLAY;
                        end
                    end
                    if (!tap_hit && !play_hit) begin
                        res_handle = '0;
                        res_len    = '0;
                        res_time   = '0;
                    end
                end
            end
            tpq_pkg::OP_FLUSH: begin
                n_rp     = '0;
                n_wp     = '0;
                n_tapped = 1'b0;
            end
            tpq_pkg::OP_SET_SKIP:  n_skip  = r_cmd.opnd;
            tpq_pkg::OP_SET_PAUSE: n_pause = r_cmd.opnd;
            tpq_pkg::OP_SET_START: begin
                if (r_active) begin
                    n_start = r_cmd.opnd;
                end
            end
            tpq_pkg::OP_START: begin
                if (!r_active) begin
                    n_active = 1'b1;
                    n_rp     = '0;
                    n_wp     = '0;
                    n_start  = '0;
                    n_tapped = 1'b0;
                end
            end
            tpq_pkg::OP_STOP: n_active = 1'b0;
            default: ;
        endcase
    end

    // occupancy and newest time after the step
    assign occ_next    = f_occ(n_wp, n_rp);
    assign occ_wide    = QW'(occ_next);
    assign newest_next = (occ_next != '0) ? n_newest : '0;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= tpq_pkg::ST_IDLE;
            r_rp     <= '0;
            r_wp     <= '0;
            r_tapped <= 1'b0;
            r_skip   <= '0;
            r_pause  <= '0;
            r_start  <= '0;
            r_active <= 1'b0;
        end else begin
            r_state <= n_state;
            if (exec_go) begin
                r_rp     <= n_rp;
                r_wp     <= n_wp;
                r_tapped <= n_tapped;
                r_skip   <= n_skip;
                r_pause  <= n_pause;
                r_start  <= n_start;
                r_active <= n_active;
            end
        end
    end

    // command hold and newest play time
    always_ff @(posedge i_clk) begin
        if (cmd_pop) begin
            r_cmd <= i_cmd;
        end
        if (exec_go) begin
            r_newest <= n_newest;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tap_enable    <= 1'b0;
            r_cfg.lookahead_ms  <= tpq_pkg::LOOKAHEAD_RST;
            r_cfg.silence_len   <= tpq_pkg::SILENCE_LEN_RST;
            r_cfg.max_frame_len <= tpq_pkg::MAX_FRAME_LEN_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tpq_pkg::CFG_TAP_ENABLE:    r_cfg.tap_enable    <= i_cfg_data[0];
                tpq_pkg::CFG_LOOKAHEAD_MS:  r_cfg.lookahead_ms  <= i_cfg_data[tpq_pkg::LOOK_W-1:0];
                tpq_pkg::CFG_SILENCE_LEN:   r_cfg.silence_len   <= i_cfg_data;
                tpq_pkg::CFG_MAX_FRAME_LEN: r_cfg.max_frame_len <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ring memory, head read every cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_wp] <= '{handle: r_cmd.handle, len: r_cmd.len,
                             play_time: r_cmd.opnd};
        end
        r_rd <= r_mem[r_rp];
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec_go || second_go) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_go) begin
            r_out_kind   <= res_kind;
            r_out_handle <= res_handle;
            r_out_len    <= res_len;
            r_out_time   <= res_time;
            r_out_queued <= occ_wide[tpq_pkg::QUEUED_W-1:0];
            r_out_newest <= newest_next;
            r_out_last   <= !res_two;
        end else if (second_go) begin
            r_out_kind <= tpq_pkg::KIND_PLAY;
            r_out_last <= 1'b1;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_kind          = r_out_kind;
    assign o_out_handle    = r_out_handle;
    assign o_out_len       = r_out_len;
    assign o_out_time      = r_out_time;
    assign o_frames_queued = r_out_queued;
    assign o_newest_time   = r_out_newest;
    assign o_last          = r_out_last;

    // checks
    `TPQ_ASSERT(a_ptr_range, ((PTR_W + 1)'(r_rp) < SLOTS) && ((PTR_W + 1)'(r_wp) < SLOTS), "ring pointer out of range")
    `TPQ_ASSERT_IMP(a_second_after_tap, r_state == tpq_pkg::ST_SECOND, r_out_valid && (r_out_kind == tpq_pkg::KIND_TAP) && !r_out_last, "play follows no pending tap")
    `TPQ_ASSERT_IMP(a_only_tap_not_last, r_out_valid && !r_out_last, r_out_kind == tpq_pkg::KIND_TAP, "non-final result is not a tap")

endmodule

/* rtl/timestamped_playout_queue.sv */
`timescale 1ns / 1ps

// Timestamped playout queue: a ring of frame descriptors released by time.
// An input transfer enters an input register, is classified and waits in a
// two-entry command queue; the execution side pops a command while the
// ring head is registered from the descriptor memory, then executes it in
// a state that waits while a result is stalled; a tick that both taps and
// plays the head adds a second state for the play. The next command waits
// for the last to finish. Results leave through an output register; the
// queue takes transfers while a result is stalled until the command queue
// and input register fill. Configuration is written through its own port,
// always ready; the user must write it only while the block is idle, which
// the block does not enforce. The ring memory needs no clearing after reset.
module timestamped_playout_queue #(
    parameter int RING_SLOTS = tpq_pkg::RING_SLOTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [2:0]                     i_op,
    input  logic [tpq_pkg::HANDLE_W-1:0]   i_frame_handle,
    input  logic [tpq_pkg::LEN_IN_W-1:0]   i_frame_len,
    input  logic [tpq_pkg::TIME_W-1:0]     i_time_value,
    input  logic [tpq_pkg::TIME_W-1:0]     i_now_ms,
    input  logic [tpq_pkg::TIME_W-1:0]     i_count,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [tpq_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tpq_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [2:0]                     o_kind,
    output logic [tpq_pkg::HANDLE_W-1:0]   o_out_handle,
    output logic [tpq_pkg::LEN_W-1:0]      o_out_len,
    output logic [tpq_pkg::TIME_W-1:0]     o_out_time,
    output logic [tpq_pkg::QUEUED_W-1:0]   o_frames_queued,
    output logic [tpq_pkg::TIME_W-1:0]     o_newest_time,
    output logic                           o_last
);

    tpq_pkg::t_cfg cfg;
    tpq_pkg::t_cmd front_cmd;
    tpq_pkg::t_cmd queue_cmd;
    logic          push_valid;
    logic          push_ready;
    logic          pop_valid;
    logic          pop;

    // front end: input register and classification
    tpq_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_op           (i_op),
        .i_frame_handle (i_frame_handle),
        .i_frame_len    (i_frame_len),
        .i_time_value   (i_time_value),
        .i_now_ms       (i_now_ms),
        .i_count        (i_count),
        .i_cfg          (cfg),
        .o_push_valid   (push_valid),
        .o_cmd          (front_cmd),
        .i_push_ready   (push_ready)
    );

    // command queue between the two sides
    tpq_cmd_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_cmd        (front_cmd),
        .o_pop_valid  (pop_valid),
        .i_pop        (pop),
        .o_cmd        (queue_cmd)
    );

    // execution side: ring, pointers, counters and result register
    tpq_back #(
        .RING_SLOTS (RING_SLOTS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_valid     (pop_valid),
        .o_cmd_pop       (pop),
        .i_cmd           (queue_cmd),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_cfg           (cfg),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_kind          (o_kind),
        .o_out_handle    (o_out_handle),
        .o_out_len       (o_out_len),
        .o_out_time      (o_out_time),
        .o_frames_queued (o_frames_queued),
        .o_newest_time   (o_newest_time),
        .o_last          (o_last)
    );

endmodule
